/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the triangle normal block.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while in reset
`define ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication, disabled while in reset
`define ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMP(lbl, ck, rn, ante, cons)
`define ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

/* rtl/core/ftn_pkg.sv */
// Types and constants of the flat triangle normal block.
// No dependencies; used by the channel interfaces and the top level.
package ftn_pkg;

  localparam int CRD_W  = 16;
  localparam int NRM_W  = 16;

  // square root: two root bits per stage
  localparam int SQ_STG = 16;
  localparam int SQ_PER = 2;
  // divider: fifteen quotient bits, three per stage
  localparam int DV_STG = 5;
  localparam int DV_PER = 3;
  localparam int Q_W    = DV_STG * DV_PER;

  // output beat codes
  localparam logic [1:0] BEAT_0 = 2'd0;
  localparam logic [1:0] BEAT_1 = 2'd1;
  localparam logic [1:0] BEAT_2 = 2'd2;

  // corner order: c0x c0y c0z c1x c1y c1z c2x c2y c2z
  typedef struct packed {
    logic [8:0][CRD_W-1:0] crd;
    logic                  fin;
  } tri_t;

  typedef logic signed [NRM_W-1:0] nrm_t;

endpackage

/* rtl/core/ftn_in_if.sv */
// Input channel of the triangle normal block: one triangle per transaction.
// Depends on ftn_pkg.
interface ftn_in_if;
  import ftn_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] corner0_x;
  logic signed [CRD_W-1:0] corner0_y;
  logic signed [CRD_W-1:0] corner0_z;
  logic signed [CRD_W-1:0] corner1_x;
  logic signed [CRD_W-1:0] corner1_y;
  logic signed [CRD_W-1:0] corner1_z;
  logic signed [CRD_W-1:0] corner2_x;
  logic signed [CRD_W-1:0] corner2_y;
  logic signed [CRD_W-1:0] corner2_z;
  logic                    final_triangle;

  modport source (
    output valid, corner0_x, corner0_y, corner0_z, corner1_x, corner1_y, corner1_z,
           corner2_x, corner2_y, corner2_z, final_triangle,
    input  ready
  );
  modport sink (
    input  valid, corner0_x, corner0_y, corner0_z, corner1_x, corner1_y, corner1_z,
           corner2_x, corner2_y, corner2_z, final_triangle,
    output ready
  );
endinterface

/* rtl/core/ftn_out_if.sv */
// Result channel of the triangle normal block: one vertex per transaction.
// Depends on ftn_pkg.
interface ftn_out_if;
  import ftn_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] vertex_x;
  logic signed [CRD_W-1:0] vertex_y;
  logic signed [CRD_W-1:0] vertex_z;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic signed [NRM_W-1:0] normal_z;
  logic                    last_of_triangle;
  logic                    mesh_end;

  modport source (
    output valid, vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z,
           last_of_triangle, mesh_end,
    input  ready
  );
  modport sink (
    input  valid, vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z,
           last_of_triangle, mesh_end,
    output ready
  );
endinterface

/* rtl/core/flat_triangle_normal_expander.sv */
// Flat triangle normal expander: takes a triangle, forms the unit face normal
// (Q1.14) of its corners, and emits the three corners with it as three vertices.
// From the input transaction to the first vertex, a triangle passes a 30-stage
// pipeline (edge differences, cross product, scaling, a 16-stage square root at two
// root bits per stage, a 5-stage divider at three quotient bits per stage) and one
// output register. A triangle enters in any cycle the pipeline moves; sustained
// throughput is set by the three vertex transactions per triangle on the result
// channel. A degenerate triangle gets a zero normal.
// Depends on ftn_pkg, ftn_in_if, ftn_out_if and assert_macros.svh.
`include "assert_macros.svh"

module flat_triangle_normal_expander (
  input  logic clk,
  input  logic rst_n,
  ftn_in_if.sink    in_ch,
  ftn_out_if.source out_ch
);
  import ftn_pkg::*;

  localparam int S_DIF = 0;
  localparam int S_PRD = 1;
  localparam int S_ABS = 2;
  localparam int S_MSB = 3;
  localparam int S_SHF = 4;
  localparam int S_SQR = 5;
  localparam int S_SUM = 6;
  localparam int S_SQ0 = 7;
  localparam int S_DVI = S_SQ0 + SQ_STG;
  localparam int S_DV0 = S_DVI + 1;
  localparam int S_NRM = S_DV0 + DV_STG;
  localparam int NSTG  = S_NRM + 1;

  logic            en;
  logic [NSTG-1:0] vld_r;
  tri_t            pay_r [NSTG];
  tri_t            pay_in;

  logic signed [16:0] dif_r [6];
  logic signed [33:0] prd_r [6];
  logic [33:0]        abs_r [3];
  logic [33:0]        abm_r [3];
  logic [5:0]         msb_r;
  logic [2:0]         neg_r [S_ABS:S_NRM];
  logic               zro_r [S_ABS:S_NRM];
  logic [2:0][30:0]   shv_r [S_SHF:S_DVI];
  logic [61:0]        sq_r [3];
  logic [63:0]        sum_r;

  logic [31:0] rt_r  [SQ_STG];
  logic [34:0] rm_r  [SQ_STG];
  logic [63:0] rad_r [SQ_STG];

  logic [2:0][33:0]    drm_r [DV_STG+1];
  logic [2:0][14:0]    dnl_r [DV_STG+1];
  logic [2:0][Q_W-1:0] dq_r  [DV_STG+1];
  logic [32:0]         dd_r  [DV_STG+1];

  nrm_t nrm_r [3];

  logic       ex_v_r;
  logic [1:0] beat_r;
  tri_t       ex_pay_r;
  nrm_t       ex_nrm_r [3];

  // Advance the whole pipeline unless the last stage is blocked by the output
  assign en = !vld_r[NSTG-1] || !ex_v_r || (out_ch.ready && beat_r == BEAT_2);
  assign in_ch.ready = en;

  assign pay_in.crd = {in_ch.corner2_z, in_ch.corner2_y, in_ch.corner2_x,
                       in_ch.corner1_z, in_ch.corner1_y, in_ch.corner1_x,
                       in_ch.corner0_z, in_ch.corner0_y, in_ch.corner0_x};
  assign pay_in.fin = in_ch.final_triangle;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_ch.valid};
    end
  end

  // Carry the triangle payload down the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      pay_r[0] <= pay_in;
      for (int s = 1; s < NSTG; s++) pay_r[s] <= pay_r[s-1];
    end
  end

  // Edge vectors, cross product terms, magnitudes
  logic signed [34:0] crs [3];
  logic [33:0]        orv;
  logic [5:0]         msb_nxt;

  always_comb begin
    crs[0] = 35'(prd_r[0]) - 35'(prd_r[1]);
    crs[1] = 35'(prd_r[2]) - 35'(prd_r[3]);
    crs[2] = 35'(prd_r[4]) - 35'(prd_r[5]);
    orv = abs_r[0] | abs_r[1] | abs_r[2];
    msb_nxt = '0;
    for (int i = 0; i < 34; i++) begin
      if (orv[i]) msb_nxt = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dif_r[k]   <= $signed({pay_in.crd[3+k][15], pay_in.crd[3+k]})
                    - $signed({pay_in.crd[k][15], pay_in.crd[k]});
        dif_r[3+k] <= $signed({pay_in.crd[6+k][15], pay_in.crd[6+k]})
                    - $signed({pay_in.crd[k][15], pay_in.crd[k]});
      end
      // u = dif[0..2], v = dif[3..5]
      prd_r[0] <= dif_r[1] * dif_r[5];
      prd_r[1] <= dif_r[2] * dif_r[4];
      prd_r[2] <= dif_r[2] * dif_r[3];
      prd_r[3] <= dif_r[0] * dif_r[5];
      prd_r[4] <= dif_r[0] * dif_r[4];
      prd_r[5] <= dif_r[1] * dif_r[3];
      for (int k = 0; k < 3; k++) begin
        abs_r[k]    <= crs[k][34] ? 34'(-crs[k]) : crs[k][33:0];
        neg_r[S_ABS][k] <= crs[k][34];
      end
      zro_r[S_ABS] <= (crs[0] == '0) && (crs[1] == '0) && (crs[2] == '0);
      abm_r <= abs_r;
      msb_r <= msb_nxt;
      for (int s = S_ABS + 1; s <= S_NRM; s++) begin
        neg_r[s] <= neg_r[s-1];
        zro_r[s] <= zro_r[s-1];
      end
    end
  end

  // Scale the magnitudes so the largest has its top bit at position 30
  logic [2:0][30:0] shv_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (msb_r > 6'd30) shv_nxt[k] = 31'(abm_r[k] >> (msb_r - 6'd30));
      else               shv_nxt[k] = 31'(abm_r[k] << (6'd30 - msb_r));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      shv_r[S_SHF] <= shv_nxt;
      for (int s = S_SHF + 1; s <= S_DVI; s++) shv_r[s] <= shv_r[s-1];
      for (int k = 0; k < 3; k++) sq_r[k] <= shv_r[S_SHF][k] * shv_r[S_SHF][k];
      sum_r <= 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]);
    end
  end

  // Square root, two root bits per stage
  for (genvar g = 0; g < SQ_STG; g++) begin : g_sqrt
    logic [31:0] rt_in, rt_o;
    logic [34:0] rm_in, rm_o, trl;
    logic [63:0] rad_in, rad_o;

    if (g == 0) begin : g_first
      assign rt_in  = '0;
      assign rm_in  = '0;
      assign rad_in = sum_r;
    end else begin : g_rest
      assign rt_in  = rt_r[g-1];
      assign rm_in  = rm_r[g-1];
      assign rad_in = rad_r[g-1];
    end

    always_comb begin
      rt_o  = rt_in;
      rm_o  = rm_in;
      rad_o = rad_in;
      trl   = '0;
      for (int j = 0; j < SQ_PER; j++) begin
        rm_o  = {rm_o[32:0], rad_o[63:62]};
        rad_o = {rad_o[61:0], 2'b00};
        trl   = {1'b0, rt_o, 2'b01};
        if (rm_o >= trl) begin
          rm_o = rm_o - trl;
          rt_o = {rt_o[30:0], 1'b1};
        end else begin
          rt_o = {rt_o[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt_r[g]  <= rt_o;
        rm_r[g]  <= rm_o;
        rad_r[g] <= rad_o;
      end
    end
  end

  // Divider setup: numerator a*2^15 + L, divisor 2L
  logic [2:0][46:0] num;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = 47'({shv_r[S_DVI-1][k], 15'd0}) + 47'(rt_r[SQ_STG-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        drm_r[0][k] <= 34'(num[k][46:15]);
        dnl_r[0][k] <= num[k][14:0];
        dq_r[0][k]  <= '0;
      end
      dd_r[0] <= {rt_r[SQ_STG-1], 1'b0};
    end
  end

  // Restoring divide, three quotient bits per stage
  for (genvar g = 1; g <= DV_STG; g++) begin : g_div
    logic [2:0][33:0]    rm_o;
    logic [2:0][14:0]    nl_o;
    logic [2:0][Q_W-1:0] q_o;

    always_comb begin
      rm_o = drm_r[g-1];
      nl_o = dnl_r[g-1];
      q_o  = dq_r[g-1];
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < DV_PER; j++) begin
          rm_o[k] = {rm_o[k][32:0], nl_o[k][14]};
          nl_o[k] = {nl_o[k][13:0], 1'b0};
          if (rm_o[k] >= 34'(dd_r[g-1])) begin
            rm_o[k] = rm_o[k] - 34'(dd_r[g-1]);
            q_o[k]  = {q_o[k][Q_W-2:0], 1'b1};
          end else begin
            q_o[k]  = {q_o[k][Q_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        drm_r[g] <= rm_o;
        dnl_r[g] <= nl_o;
        dq_r[g]  <= q_o;
        dd_r[g]  <= dd_r[g-1];
      end
    end
  end

  // Apply sign, zero the normal of a degenerate triangle
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (zro_r[S_NRM-1])           nrm_r[k] <= '0;
        else if (neg_r[S_NRM-1][k])   nrm_r[k] <= -$signed({1'b0, dq_r[DV_STG][k]});
        else                          nrm_r[k] <= $signed({1'b0, dq_r[DV_STG][k]});
      end
    end
  end

  // Output register: emit three vertices per triangle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_v_r <= 1'b0;
      beat_r <= BEAT_0;
    end else if (en && vld_r[NSTG-1]) begin
      ex_v_r <= 1'b1;
      beat_r <= BEAT_0;
    end else if (ex_v_r && out_ch.ready) begin
      if (beat_r == BEAT_2) ex_v_r <= 1'b0;
      else                  beat_r <= beat_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_r[NSTG-1]) begin
      ex_pay_r <= pay_r[NSTG-1];
      ex_nrm_r <= nrm_r;
    end
  end

  logic [1:0][0:0] unused_sel;
  assign unused_sel = '0;

  always_comb begin
    case (beat_r)
      BEAT_0: begin
        out_ch.vertex_x = $signed(ex_pay_r.crd[0]);
        out_ch.vertex_y = $signed(ex_pay_r.crd[1]);
        out_ch.vertex_z = $signed(ex_pay_r.crd[2]);
      end
      BEAT_1: begin
        out_ch.vertex_x = $signed(ex_pay_r.crd[3]);
        out_ch.vertex_y = $signed(ex_pay_r.crd[4]);
        out_ch.vertex_z = $signed(ex_pay_r.crd[5]);
      end
      default: begin
        out_ch.vertex_x = $signed(ex_pay_r.crd[6]);
        out_ch.vertex_y = $signed(ex_pay_r.crd[7]);
        out_ch.vertex_z = $signed(ex_pay_r.crd[8]);
      end
    endcase
  end

  assign out_ch.valid            = ex_v_r;
  assign out_ch.normal_x         = ex_nrm_r[0];
  assign out_ch.normal_y         = ex_nrm_r[1];
  assign out_ch.normal_z         = ex_nrm_r[2];
  assign out_ch.last_of_triangle = (beat_r == BEAT_2) && (unused_sel == '0);
  assign out_ch.mesh_end         = (beat_r == BEAT_2) && ex_pay_r.fin;

  // Checks
  logic        nrm_in_range;
  logic [31:0] root_fin;

  assign nrm_in_range = (out_ch.normal_x <= 16384) && (out_ch.normal_x >= -16384) &&
                        (out_ch.normal_y <= 16384) && (out_ch.normal_y >= -16384) &&
                        (out_ch.normal_z <= 16384) && (out_ch.normal_z >= -16384);
  assign root_fin = rt_r[SQ_STG-1];

  `ASSERT_IMP(a_nrm_range, clk, rst_n, out_ch.valid, nrm_in_range)
  `ASSERT_IMP(a_mesh_last, clk, rst_n, out_ch.valid && out_ch.mesh_end, out_ch.last_of_triangle)
  `ASSERT_IMP(a_root_norm, clk, rst_n, vld_r[S_DVI-1] && !zro_r[S_DVI-1], |root_fin[31:30])
  `ASSERT_NXT(a_beat_hold, clk, rst_n, ex_v_r && !out_ch.ready, ex_v_r && $stable(beat_r))

endmodule
